// File: rtl/hmmd_pkg.sv
// Shared types, codes and address-map constants for the memory map decoder.
`timescale 1ns / 1ps

package hmmd_pkg;

  // Store sizes.
  localparam int VIDEO_DEPTH     = 8192;
  localparam int WORK_BANK_DEPTH = 4096;
  localparam int HIGH_DEPTH      = 127;

  // The video store and both work banks share one memory: video first, then work.
  localparam int MAIN_DEPTH = VIDEO_DEPTH + 2 * WORK_BANK_DEPTH;
  localparam int MAIN_AW    = $clog2(MAIN_DEPTH);
  localparam int HIGH_AW    = $clog2(HIGH_DEPTH);

  // Address map boundaries.
  localparam logic [15:0] BOOT_LAST    = 16'h00FF;
  localparam logic [15:0] CART_LAST    = 16'h7FFF;
  localparam logic [15:0] VIDEO_BASE   = 16'h8000;
  localparam logic [15:0] VIDEO_LAST   = 16'h9FFF;
  localparam logic [15:0] WORK_BASE    = 16'hC000;
  localparam logic [15:0] WORK_LAST    = 16'hDFFF;
  localparam logic [15:0] HIGH_BASE    = 16'hFF80;
  localparam logic [15:0] HIGH_LAST    = 16'hFFFE;
  localparam logic [15:0] ADDR_IFLAG   = 16'hFF0F;
  localparam logic [15:0] ADDR_SND_LO  = 16'hFF11;
  localparam logic [15:0] ADDR_SND_HI  = 16'hFF14;
  localparam logic [15:0] ADDR_SND_VOL = 16'hFF25;
  localparam logic [15:0] ADDR_SND_ON  = 16'hFF26;
  localparam logic [15:0] ADDR_LCDC    = 16'hFF40;
  localparam logic [15:0] ADDR_SCY     = 16'hFF42;
  localparam logic [15:0] ADDR_SCX     = 16'hFF43;
  localparam logic [15:0] ADDR_LY      = 16'hFF44;
  localparam logic [15:0] ADDR_BGP     = 16'hFF47;
  localparam logic [15:0] ADDR_BOOTOFF = 16'hFF50;
  localparam logic [15:0] ADDR_IENABLE = 16'hFFFF;

  // Command codes.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Target codes.
  localparam logic [2:0] TGT_INTERNAL = 3'd0;
  localparam logic [2:0] TGT_BOOT     = 3'd1;
  localparam logic [2:0] TGT_CART     = 3'd2;
  localparam logic [2:0] TGT_VIDEO    = 3'd3;
  localparam logic [2:0] TGT_SOUND    = 3'd4;
  localparam logic [2:0] TGT_IFLAG    = 3'd5;
  localparam logic [2:0] TGT_IENABLE  = 3'd6;

  // Source of the read byte of a transaction.
  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_MAIN = 2'd1,
    RD_HIGH = 2'd2
  } rd_src_t;

  // Decoded transaction: memory controls plus the routed result fields.
  typedef struct packed {
    logic               main_en;
    logic               main_we;
    logic [MAIN_AW-1:0] main_addr;
    logic               high_en;
    logic               high_we;
    logic [HIGH_AW-1:0] high_addr;
    logic               overlay_off;
    rd_src_t            rd_src;
    logic [2:0]         target;
    logic [15:0]        target_address;
    logic [7:0]         forward_data;
    logic               fault;
  } access_t;

endpackage

// File: rtl/hmmd_ram.sv
// Generic single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps

module hmmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry; the read data holds until the next read.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: rtl/hmmd_decode.sv
// Address decoder: maps one bus transaction onto stores and external targets.
`timescale 1ns / 1ps

module hmmd_decode import hmmd_pkg::*; (
  input  logic        cmd,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic        boot_overlay,
  output access_t     acc
);

  logic in_video;
  logic in_work;
  logic in_high;
  logic [MAIN_AW-1:0] video_idx;
  logic [MAIN_AW-1:0] work_idx;

  // Region hits shared by reads and writes.
  assign in_video  = (address >= VIDEO_BASE) && (address <= VIDEO_LAST);
  assign in_work   = (address >= WORK_BASE) && (address <= WORK_LAST);
  assign in_high   = (address >= HIGH_BASE) && (address <= HIGH_LAST);
  assign video_idx = MAIN_AW'(address - VIDEO_BASE);
  assign work_idx  = MAIN_AW'(VIDEO_DEPTH) + MAIN_AW'(address - WORK_BASE);

  // Decode the transaction by kind and region.
  always_comb begin
    acc                = '0;
    acc.rd_src         = RD_NONE;
    acc.main_we        = (cmd == CMD_WRITE);
    acc.high_we        = (cmd == CMD_WRITE);
    acc.high_addr      = HIGH_AW'(address - HIGH_BASE);
    acc.main_addr      = in_work ? work_idx : video_idx;
    acc.target         = TGT_INTERNAL;
    if (cmd == CMD_READ) begin
      if (address <= BOOT_LAST) begin
        acc.target = boot_overlay ? TGT_BOOT : TGT_CART;
      end else if (address <= CART_LAST) begin
        acc.target = TGT_CART;
      end else if (in_video || in_work) begin
        acc.main_en = 1'b1;
        acc.rd_src  = RD_MAIN;
      end else if (address == ADDR_SCY || address == ADDR_LY) begin
        acc.target = TGT_VIDEO;
      end else if (in_high) begin
        acc.high_en = 1'b1;
        acc.rd_src  = RD_HIGH;
      end else begin
        acc.fault = 1'b1;
      end
    end else begin
      if (in_video || in_work) begin
        acc.main_en = 1'b1;
      end else if (in_high) begin
        acc.high_en = 1'b1;
      end else if (address == ADDR_BOOTOFF) begin
        acc.overlay_off = 1'b1;
      end else if (address == ADDR_IFLAG) begin
        acc.target = TGT_IFLAG;
      end else if (address == ADDR_IENABLE) begin
        acc.target = TGT_IENABLE;
      end else if ((address >= ADDR_SND_LO && address <= ADDR_SND_HI) ||
                   address == ADDR_SND_VOL || address == ADDR_SND_ON) begin
        acc.target = TGT_SOUND;
      end else if (address == ADDR_LCDC || address == ADDR_SCY ||
                   address == ADDR_SCX || address == ADDR_BGP) begin
        acc.target = TGT_VIDEO;
      end else begin
        acc.fault = 1'b1;
      end
    end
    // Routed transactions carry the bus address, and writes their byte.
    if (acc.target != TGT_INTERNAL) begin
      acc.target_address = address;
      if (cmd == CMD_WRITE) begin
        acc.forward_data = write_data;
      end
    end
  end

endmodule

// File: rtl/handheld_memory_map_decoder_unit.sv
// Top level of the memory map decoder: decode stage, stores and result register.
// A transaction enters the memory stage when accepted and moves on to the result register,
// where out_valid rises; it waits in the memory stage while the result register is stalled.
// Throughput: one transaction per cycle while the result side does not stall;
// each transaction makes at most one access to a single-port store, and that port sets the rate.
// Reset clears the valid flags and sets the boot overlay; the stores are not
// cleared and hold undefined data until written.
`timescale 1ns / 1ps

module handheld_memory_map_decoder_unit import hmmd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic [2:0]  target,
  output logic [15:0] target_address,
  output logic [7:0]  forward_data,
  output logic        fault
);

  access_t    acc;
  access_t    acc_q;
  logic       boot_overlay;
  logic       mem_valid;
  logic       in_accept;
  logic       out_free;
  logic       advance;
  logic [7:0] main_rdata;
  logic [7:0] high_rdata;
  logic [7:0] read_data_next;

  // Handshake: the memory stage waits only when the result register is full and stalled.
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = mem_valid && !out_free;
  assign in_accept = in_valid && !in_stall;
  assign advance   = mem_valid && out_free;

  hmmd_decode u_decode (
    .cmd          (cmd),
    .address      (address),
    .write_data   (write_data),
    .boot_overlay (boot_overlay),
    .acc          (acc)
  );

  // Video and work RAM share one memory; high RAM has its own.
  hmmd_ram #(.WIDTH(8), .DEPTH(MAIN_DEPTH)) u_main_ram (
    .clk   (clk),
    .en    (in_accept && acc.main_en),
    .we    (acc.main_we),
    .addr  (acc.main_addr),
    .wdata (write_data),
    .rdata (main_rdata)
  );

  hmmd_ram #(.WIDTH(8), .DEPTH(HIGH_DEPTH)) u_high_ram (
    .clk   (clk),
    .en    (in_accept && acc.high_en),
    .we    (acc.high_we),
    .addr  (acc.high_addr),
    .wdata (write_data),
    .rdata (high_rdata)
  );

  // Boot overlay flag: cleared by any write to the overlay-off register.
  always_ff @(posedge clk) begin
    if (rst) begin
      boot_overlay <= 1'b1;
    end else if (in_accept && acc.overlay_off) begin
      boot_overlay <= 1'b0;
    end
  end

  // Memory stage: holds the decoded transaction while the store read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_valid <= 1'b0;
    end else if (in_accept) begin
      mem_valid <= 1'b1;
    end else if (advance) begin
      mem_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      acc_q <= acc;
    end
  end

  // Select the read byte from the store named by the decode.
  always_comb begin
    case (acc_q.rd_src)
      RD_MAIN: read_data_next = main_rdata;
      RD_HIGH: read_data_next = high_rdata;
      default: read_data_next = 8'h00;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data      <= read_data_next;
      target         <= acc_q.target;
      target_address <= acc_q.target_address;
      forward_data   <= acc_q.forward_data;
      fault          <= acc_q.fault;
    end
  end

  // A faulting transaction produces no read byte and no routing.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && fault |-> read_data == 8'h00 && target == TGT_INTERNAL &&
                           target_address == 16'h0000 && forward_data == 8'h00)
    else $error("fault result carries data");

  // Only routed transactions carry an address.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && target == TGT_INTERNAL |-> target_address == 16'h0000)
    else $error("internal result carries a target address");

  // A transaction touches at most one store.
  assert property (@(posedge clk) disable iff (rst)
    in_accept |-> $onehot0({acc.main_en, acc.high_en}))
    else $error("transaction enables both stores");

  // An accepted write to the overlay-off register clears the overlay.
  assert property (@(posedge clk) disable iff (rst)
    in_accept && cmd == CMD_WRITE && address == ADDR_BOOTOFF |=> !boot_overlay)
    else $error("boot overlay not cleared");

  // The memory stage only stalls the input when it holds a transaction.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> mem_valid && out_valid)
    else $error("input stalled with free pipeline");

endmodule
